// ----- sv/box_filter_1d_edge_replicate_core_defines.svh -----
// Assertion macros shared by the box filter RTL.
// Needs clk and rst_n in the scope of the including module; no other dependencies.
`ifndef BOX_FILTER_1D_EDGE_REPLICATE_CORE_DEFINES_SVH
`define BOX_FILTER_1D_EDGE_REPLICATE_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define BFE_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define BFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/bfe_pkg.sv -----
// Shared constants and controller/datapath command and status types
// for the box filter. No dependencies.
package bfe_pkg;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = CFG_ADDR_W - 2;

  // Register indexes.
  localparam logic [REG_IDX_W-1:0] REG_KERNEL = '0;

  // Kernel size register.
  localparam int                 KSIZE_W     = 5;
  localparam logic [KSIZE_W-1:0] KSIZE_RESET = KSIZE_W'(3);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;         // shift in the accepted beat
    logic plan;         // load the first centre position
    logic sum_init;     // clear the window sum, load lag and tap count
    logic sum_step;     // add one tap
    logic div_init;     // load the divider
    logic div_step;     // one quotient bit
    logic emit;         // write the result register
    logic next_centre;  // step the centre one sample toward the newest
    logic line_done;    // forget the line
  } bfe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_work;
    logic sum_last;
    logic div_last;
    logic centre_zero;
    logic line_end;
    logic out_free;
  } bfe_sts_t;

endpackage

// ----- sv/bfe_ifs.sv -----
// Valid/ready stream interfaces for the box filter's sample input and result output.
// No dependencies.
interface bfe_in_if #(parameter int SAMPLE_BITS = 8);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   line_end;

  modport source (output valid, output sample, output line_end, input ready);
  modport sink   (input valid, input sample, input line_end, output ready);
endinterface

interface bfe_out_if #(parameter int SAMPLE_BITS = 8);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] filtered;
  logic                   last_out;

  modport source (output valid, output filtered, output last_out, input ready);
  modport sink   (input valid, input filtered, input last_out, output ready);
endinterface

// ----- sv/box_filter_1d_edge_replicate_core.sv -----
// Channel  Direction  Beat contents             Handshake
// in_bus   input      sample, line_end          valid / ready
// out_bus  output     filtered, last_out        valid / ready
// cfg      input      kernel_size at word 0     APB write, pready tied high
//
// Each result sums the span = 2*side+1 window taps one at a time in the tap adder,
// then divides the sum bit-serially over SUM_W = SAMPLE_BITS + clog2(MAX_KERNEL+1)
// quotient bits (13 by default).
// A new sample is taken while the last result still waits in the output register.
// Reset is synchronous and active low; it clears the line state and kernel_size to 3.
// A stall on out_bus holds the sequencer before it writes the next result.
module box_filter_1d_edge_replicate_core
  import bfe_pkg::*;
#(
  parameter int SAMPLE_BITS = 8,
  parameter int MAX_KERNEL  = 31
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  bfe_in_if.sink                in_bus,
  bfe_out_if.source             out_bus,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [KSIZE_W-1:0] kernel_r;
  logic               reg_sel;
  logic               cfg_wr;
  bfe_cmd_t           cmd;
  bfe_sts_t           sts;

  // Register decode on the word index.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_KERNEL);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = reg_sel ? CFG_DATA_W'(kernel_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_r <= KSIZE_RESET;
    end else if (cfg_wr && reg_sel) begin
      kernel_r <= pwdata[KSIZE_W-1:0];
    end
  end

  // Sequencer.
  bfe_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  bfe_dpath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_KERNEL  (MAX_KERNEL)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .kernel_size  (kernel_r),
    .in_sample    (in_bus.sample),
    .in_line_end  (in_bus.line_end),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_bus.valid),
    .out_ready    (out_bus.ready),
    .out_filtered (out_bus.filtered),
    .out_last     (out_bus.last_out)
  );

endmodule

// ----- sv/bfe_ctrl.sv -----
// Sequencing state machine of the box filter.
// Depends on bfe_pkg and box_filter_1d_edge_replicate_core_defines.svh.
`include "box_filter_1d_edge_replicate_core_defines.svh"

module bfe_ctrl
  import bfe_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bfe_sts_t sts,
  output bfe_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PLAN  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_SUM   = 3'd3;
  localparam logic [2:0] S_DIV0  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_PLAN;
        end
      end
      S_PLAN: begin
        if (sts.has_work) begin
          cmd.plan  = 1'b1;
          state_nxt = S_START;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_START: begin
        cmd.sum_init = 1'b1;
        state_nxt    = S_SUM;
      end
      S_SUM: begin
        cmd.sum_step = 1'b1;
        if (sts.sum_last) begin
          state_nxt = S_DIV0;
        end
      end
      S_DIV0: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // Hold the finished result until the output register frees up.
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (sts.line_end && !sts.centre_zero) begin
            cmd.next_centre = 1'b1;
            state_nxt       = S_START;
          end else begin
            cmd.line_done = sts.line_end;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `BFE_ASSERT_HOLDS(a_emit_needs_room, cmd.emit, sts.out_free, "result written over a held beat")
  `BFE_ASSERT_HOLDS(a_cmd_exclusive, 1'b1, $onehot0({cmd.take, cmd.plan, cmd.sum_init, cmd.sum_step, cmd.div_init, cmd.div_step, cmd.emit}), "overlapping datapath commands")
  `BFE_ASSERT_HOLDS(a_done_on_last, cmd.line_done, cmd.emit && sts.centre_zero && sts.line_end, "line cleared before its last result")
  `BFE_ASSERT_NEXT(a_take_plans, cmd.take, state_r == S_PLAN, "accepted beat not planned")

endmodule

// ----- sv/bfe_dpath.sv -----
// Datapath of the box filter: sample history, tap adder, bit-serial divider
// and result register. Depends on bfe_pkg.
module bfe_dpath
  import bfe_pkg::*;
#(
  parameter int SAMPLE_BITS = 8,
  parameter int MAX_KERNEL  = 31
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [KSIZE_W-1:0]     kernel_size,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_line_end,
  input  bfe_cmd_t               cmd,
  output bfe_sts_t               sts,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] out_filtered,
  output logic                   out_last
);

  localparam int HIST_DEPTH = MAX_KERNEL + 1;
  localparam int K_W        = $clog2(MAX_KERNEL + 1);
  localparam int LAG_W      = K_W + 1;
  localparam int SUM_W      = SAMPLE_BITS + K_W;
  localparam int DCNT_W     = $clog2(SUM_W);

  logic [SAMPLE_BITS-1:0] hist_r [HIST_DEPTH];
  logic [SAMPLE_BITS-1:0] first_r;
  logic [K_W-1:0]         seen_r;
  logic                   end_r;
  logic [K_W-1:0]         centre_r;
  logic [LAG_W-1:0]       lag_r;
  logic [K_W-1:0]         taps_r;
  logic [SUM_W-1:0]       acc_r;
  logic [SUM_W-1:0]       quo_r;
  logic [K_W-1:0]         rem_r;
  logic [DCNT_W-1:0]      dcnt_r;
  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_filtered_r;
  logic                   out_last_r;

  logic [K_W-1:0]         k_eff;
  logic [K_W-1:0]         side;
  logic [K_W-1:0]         span;
  logic [K_W-1:0]         seen_nxt;
  logic [K_W-1:0]         top_centre;
  logic [K_W-1:0]         centre_nxt;
  logic [K_W-1:0]         lag_mag;
  logic [SAMPLE_BITS-1:0] tap;
  logic [SUM_W-1:0]       acc_nxt;
  logic [K_W:0]           trial;
  logic [K_W:0]           trial_diff;
  logic                   trial_ge;
  logic [K_W-1:0]         rem_nxt;

  // Effective kernel: zero acts as one, oversized clamps to the maximum.
  always_comb begin
    if (kernel_size == '0) begin
      k_eff = K_W'(1);
    end else if (32'(kernel_size) > MAX_KERNEL) begin
      k_eff = K_W'(MAX_KERNEL);
    end else begin
      k_eff = K_W'(kernel_size);
    end
  end

  assign side = (k_eff - K_W'(1)) >> 1;
  assign span = K_W'({side, 1'b1});

  // Fill count saturates at the window span.
  assign seen_nxt = (seen_r < span) ? seen_r + K_W'(1) : span;

  // First centre: the oldest pending one at line end, else the side width.
  assign top_centre = seen_r - K_W'(1);
  assign centre_nxt = (end_r && (top_centre < side)) ? top_centre : side;

  // Tap select: ahead of the newest repeats it, behind the line start repeats the first.
  assign lag_mag = lag_r[K_W-1:0];
  always_comb begin
    if (lag_r[LAG_W-1]) begin
      tap = hist_r[0];
    end else if (lag_mag >= seen_r) begin
      tap = first_r;
    end else begin
      tap = hist_r[lag_mag];
    end
  end

  assign acc_nxt = acc_r + SUM_W'(tap);

  // Restoring division, one quotient bit per cycle.
  assign trial      = {rem_r, quo_r[SUM_W-1]};
  assign trial_ge   = trial >= {1'b0, k_eff};
  assign trial_diff = trial - {1'b0, k_eff};
  assign rem_nxt    = trial_ge ? trial_diff[K_W-1:0] : trial[K_W-1:0];

  // Sample history shift line.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      hist_r[0] <= in_sample;
      for (int i = 1; i < HIST_DEPTH; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  // Line state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= '0;
      seen_r  <= '0;
      end_r   <= 1'b0;
    end else if (cmd.take) begin
      if (seen_r == '0) begin
        first_r <= in_sample;
      end
      seen_r <= seen_nxt;
      end_r  <= in_line_end;
    end else if (cmd.line_done) begin
      seen_r <= '0;
    end
  end

  // Centre, lag and tap counters.
  always_ff @(posedge clk) begin
    if (cmd.plan) begin
      centre_r <= centre_nxt;
    end else if (cmd.next_centre) begin
      centre_r <= centre_r - K_W'(1);
    end
    if (cmd.sum_init) begin
      lag_r  <= {1'b0, centre_r} - {1'b0, side};
      taps_r <= span - K_W'(1);
    end else if (cmd.sum_step) begin
      lag_r  <= lag_r + LAG_W'(1);
      taps_r <= taps_r - K_W'(1);
    end
  end

  // Window sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else if (cmd.sum_init) begin
      acc_r <= '0;
    end else if (cmd.sum_step) begin
      acc_r <= acc_nxt;
    end
  end

  // Divider registers.
  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo_r  <= acc_r;
      rem_r  <= '0;
      dcnt_r <= DCNT_W'(SUM_W - 1);
    end else if (cmd.div_step) begin
      quo_r  <= {quo_r[SUM_W-2:0], trial_ge};
      rem_r  <= rem_nxt;
      dcnt_r <= dcnt_r - DCNT_W'(1);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_filtered_r <= quo_r[SAMPLE_BITS-1:0];
      out_last_r     <= end_r && (centre_r == '0);
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;
  assign out_last     = out_last_r;

  // Status toward the controller.
  always_comb begin
    sts.has_work    = end_r || (seen_r > side);
    sts.sum_last    = (taps_r == '0);
    sts.div_last    = (dcnt_r == '0);
    sts.centre_zero = (centre_r == '0);
    sts.line_end    = end_r;
    sts.out_free    = !out_valid_r || out_ready;
  end

endmodule

// ----- tb/bfe_avg_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the box filter: snoops the APB port and both streams, predicts each
// window average and compares every output beat. Depends on bfe_pkg and bfe_ifs.sv.
module bfe_avg_checker
  import bfe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  bfe_in_if                     in_mon,
  bfe_out_if                    out_mon,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic [CFG_DATA_W-1:0] prdata,
  output int                    mismatches,
  output int                    results_due
);

  typedef struct packed {
    logic [7:0] filtered;
    logic       last_out;
  } avg_beat_t;

  localparam int                    HIST_DEPTH  = 32;
  localparam logic [CFG_ADDR_W-1:0] KERNEL_ADDR = {REG_KERNEL, 2'b00};

  // Shadow copy of the kernel register and of the line state.
  logic [KSIZE_W-1:0] kernel_reg;
  logic [7:0]         line_hist [HIST_DEPTH];
  logic [7:0]         line_first;
  int                 line_held;
  int                 mismatch_total;
  avg_beat_t          expected_avg_q [$];

  assign mismatches = mismatch_total;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_total++;
  endtask

  // Sample at a given lag behind the newest one. A negative lag lies past the end of
  // the line and repeats the newest; lags beyond what the line holds repeat its first.
  function automatic logic [7:0] tap_at(input int lag);
    if (lag < 0) return line_hist[0];
    if (lag >= line_held) return line_first;
    return line_hist[lag];
  endfunction

  function automatic avg_beat_t window_average(input int centre, input int side,
                                               input int k, input logic last);
    int        sum;
    avg_beat_t beat;
    sum = 0;
    for (int lag = centre - side; lag <= centre + side; lag++) sum += tap_at(lag);
    beat.filtered = 8'(sum / k);
    beat.last_out = last;
    return beat;
  endfunction

  // Shifts one sample into the line and queues the averages that it releases.
  // The register is 5 bits wide, so only the zero kernel needs clamping here.
  task automatic predict_box_average(input logic [7:0] smp, input logic line_end);
    int k;
    int side;
    int span;
    int top;
    k    = (kernel_reg == '0) ? 1 : int'(kernel_reg);
    side = (k - 1) / 2;
    span = 2 * side + 1;
    if (line_held == 0) line_first = smp;
    for (int i = HIST_DEPTH - 1; i > 0; i--) line_hist[i] = line_hist[i - 1];
    line_hist[0] = smp;
    line_held = (line_held < span) ? line_held + 1 : span;
    if (line_end) begin
      // The end of the line flushes every centre still pending, oldest first.
      top = (line_held - 1 > side) ? side : line_held - 1;
      for (int c = top; c >= 0; c--) begin
        expected_avg_q.push_back(window_average(c, side, k, c == 0));
      end
      line_held = 0;
    end else if (line_held > side) begin
      expected_avg_q.push_back(window_average(side, side, k, 1'b0));
    end
  endtask

  always @(posedge clk) begin : scoreboard
    avg_beat_t want;
    if (!rst_n) begin
      kernel_reg     = KSIZE_RESET;
      line_held      = 0;
      line_first     = '0;
      mismatch_total = 0;
      foreach (line_hist[i]) line_hist[i] = '0;
      expected_avg_q.delete();
      results_due <= 0;
    end else begin
      // Register writes update the shadow copy; reads are checked against it.
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == KERNEL_ADDR) kernel_reg = pwdata[KSIZE_W-1:0];
        end else if (paddr == KERNEL_ADDR && prdata !== CFG_DATA_W'(kernel_reg)) begin
          report_mismatch($sformatf("kernel_size read back %0h, expected %0h",
                                    prdata, kernel_reg));
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        predict_box_average(in_mon.sample, in_mon.line_end);
      end

      // Each output beat is matched against the oldest pending average.
      if (out_mon.valid && out_mon.ready) begin
        if (expected_avg_q.size() == 0) begin
          report_mismatch($sformatf("result beat %0d/%0b with none pending",
                                    out_mon.filtered, out_mon.last_out));
        end else begin
          want = expected_avg_q.pop_front();
          if (out_mon.filtered !== want.filtered) begin
            report_mismatch($sformatf("filtered %0d, expected %0d",
                                      out_mon.filtered, want.filtered));
          end
          if (out_mon.last_out !== want.last_out) begin
            report_mismatch($sformatf("last_out %0b, expected %0b",
                                      out_mon.last_out, want.last_out));
          end
        end
      end
      results_due <= expected_avg_q.size();
    end
  end

endmodule

// ----- tb/tb_box_filter_1d_edge_replicate_core.sv -----
`timescale 1ns / 1ps
// Top of the box filter testbench: clock, reset, sample and result stream drivers,
// APB kernel writes and the verdict. Depends on bfe_pkg, bfe_ifs.sv and bfe_avg_checker.
module tb_box_filter_1d_edge_replicate_core;
  import bfe_pkg::*;

  localparam int                    SETTLE_CYCLES = 60;
  localparam int                    HOLD_CYCLES   = 400;
  localparam int                    PHASE_ITEMS   = 13;
  localparam logic [CFG_ADDR_W-1:0] KERNEL_ADDR   = {REG_KERNEL, 2'b00};

  logic                  clk;
  logic                  rst_n;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int mismatches;
  int results_due;
  bit tx_idle;
  bit rx_idle;
  int hold_asks;
  int holds_served;

  bfe_in_if  in_bus ();
  bfe_out_if out_bus ();

  box_filter_1d_edge_replicate_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bfe_avg_checker scoreboard (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .mismatches  (mismatches),
    .results_due (results_due)
  );

  // 12 ns clock.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Hard stop in case the block hangs.
  initial begin
    #8_000_000;
    $display("status: fail");
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_asks != holds_served) begin
        holds_served++;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        int gap;
        gap = rx_idle ? $urandom_range(6, 0) : 0;
        if (gap > 0) begin
          out_bus.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_bus.ready <= 1'b1;
        do @(posedge clk); while (!out_bus.valid);
      end
    end
  end

  // Offers one sample beat, after a random gap while tx_idle is set, and waits until it is taken.
  task automatic send_sample(input logic [7:0] smp, input logic last);
    int gap;
    gap = tx_idle ? $urandom_range(6, 0) : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.sample   <= smp;
    in_bus.line_end <= last;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // Stops sending, waits for every pending average, then lets the block go quiet.
  task automatic drain_and_settle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes kernel_size with random upper bits, then reads it back.
  task automatic write_kernel(input logic [KSIZE_W-1:0] k);
    logic [CFG_DATA_W-1:0] word;
    word                = $urandom();
    word[KSIZE_W-1:0]   = k;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= KERNEL_ADDR;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Random lines, mostly short, some longer than the widest window. The phase may
  // stop in the middle of a line, so the next kernel takes over mid-line.
  task automatic send_random_lines(input int items);
    int sent;
    int len;
    logic [7:0] smp;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      for (int i = 0; i < len && sent < items; i++) begin
        case ($urandom_range(7, 0))
          0:       smp = 8'd0;
          1:       smp = 8'd255;
          default: smp = 8'($urandom());
        endcase
        send_sample(smp, i == len - 1);
        sent++;
      end
    end
  endtask

  initial begin
    logic [KSIZE_W-1:0] phase_kernel [6];
    rst_n           <= 1'b0;
    in_bus.valid    <= 1'b0;
    in_bus.sample   <= '0;
    in_bus.line_end <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    tx_idle          = 1'b1;
    rx_idle          = 1'b1;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset kernel of 3: a one-sample line, extremes, a two-sample line.
    send_sample(8'd255, 1'b1);
    send_sample(8'd0, 1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd0, 1'b0);
    send_sample(8'd128, 1'b1);
    send_sample(8'd255, 1'b0);
    send_sample(8'd0, 1'b1);

    // Zero kernel passes samples straight through.
    drain_and_settle();
    write_kernel(5'd0);
    send_sample(8'd17, 1'b0);
    send_sample(8'd200, 1'b0);
    send_sample(8'd9, 1'b1);

    // Widest kernel on a line too short to fill it: all results at the line end.
    drain_and_settle();
    write_kernel(5'd31);
    repeat (4) send_sample(8'd255, 1'b0);
    send_sample(8'd255, 1'b1);

    // Even kernel: one sample fewer in the window than the divisor.
    drain_and_settle();
    write_kernel(5'd4);
    send_sample(8'd10, 1'b0);
    send_sample(8'd250, 1'b0);
    send_sample(8'd3, 1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd0, 1'b1);

    // Kernel shrinks in the middle of a line.
    drain_and_settle();
    write_kernel(5'd7);
    send_sample(8'd40, 1'b0);
    send_sample(8'd255, 1'b0);
    send_sample(8'd1, 1'b0);
    drain_and_settle();
    write_kernel(5'd3);
    send_sample(8'd77, 1'b0);
    send_sample(8'd254, 1'b1);

    // Random phases, each with its own kernel and idling mix.
    phase_kernel[0] = 5'd1;
    phase_kernel[1] = 5'd31;
    phase_kernel[2] = 5'($urandom_range(31, 0));
    phase_kernel[3] = 5'd5;
    phase_kernel[4] = 5'($urandom_range(9, 1));
    phase_kernel[5] = 5'd2;
    for (int p = 0; p < 6; p++) begin
      drain_and_settle();
      tx_idle = (p % 3 != 0);
      rx_idle = (p % 3 != 1);
      write_kernel(phase_kernel[p]);
      // Long result stall while samples keep coming, so the input backs up.
      if (p == 3) hold_asks++;
      send_random_lines(PHASE_ITEMS);
    end

    drain_and_settle();
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
